// ===== hdl/fct_pkg.sv =====
// Package for the cluster table engine: word types, codes and constants.
`timescale 1ns / 1ps
package fct_pkg;

  // Default table depth and fixed field widths.
  localparam int unsigned FCT_TABLE_ENTRIES = 65536;
  localparam int ENTRY_W = 28;
  localparam int INDEX_W = 16;
  localparam int TOTAL_W = 16;

  // Entry values with a fixed meaning.
  localparam logic [ENTRY_W-1:0] END_OF_CHAIN  = 28'hFFFFFFF;
  localparam logic [ENTRY_W-1:0] MEDIA_MARK    = 28'hFFFFFF8;
  localparam logic [ENTRY_W-1:0] CHAIN_END_MIN = 28'hFFFFFF8;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET   = 16'd65534;

  // Request opcodes.
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_ALLOC = 3'd2;
  localparam logic [2:0] OP_FREE  = 3'd3;
  localparam logic [2:0] OP_COUNT = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Request word.
  typedef struct packed {
    logic [2:0]         opcode;
    logic [INDEX_W-1:0] entry_index;
    logic [ENTRY_W-1:0] entry_value;
  } fct_req_t;

  // Result word.
  typedef struct packed {
    logic [ENTRY_W-1:0] result_value;
    logic [1:0]         status;
  } fct_rsp_t;

  // Memory access strobes from the sequencer.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } fct_mem_ctl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SCAN,
    S_FREE_TEST,
    S_FREE_WAIT,
    S_DONE
  } fct_state_t;

endpackage

// ===== hdl/fct_table_mem.sv =====
// Cluster table storage: one write port and one registered read port.
`timescale 1ns / 1ps
module fct_table_mem
  import fct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = FCT_TABLE_ENTRIES,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk,
  input  fct_mem_ctl_t       ctl,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

  // The sequencer never reads and writes the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/fct_sequencer.sv =====
// Request sequencer: clearing pass, read, write, allocate scan, free walk and count.
`timescale 1ns / 1ps
module fct_sequencer
  import fct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = FCT_TABLE_ENTRIES,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  fct_req_t           req,
  output logic               busy,
  input  logic [TOTAL_W-1:0] total,
  output logic               res_valid,
  input  logic               res_take,
  output fct_rsp_t           res,
  output fct_mem_ctl_t       mem_ctl,
  output logic [AW-1:0]      mem_wr_addr,
  output logic [ENTRY_W-1:0] mem_wr_data,
  output logic [AW-1:0]      mem_rd_addr,
  input  logic [ENTRY_W-1:0] mem_rd_data
);

  fct_state_t         state, state_next;
  logic [AW-1:0]      clr_addr;
  logic [2:0]         op;
  logic [INDEX_W-1:0] idx;
  logic [ENTRY_W-1:0] val;
  logic [ENTRY_W-1:0] link;
  logic [16:0]        scan_addr;
  logic [16:0]        scan_end;
  logic               pend;
  logic [16:0]        pend_addr;
  logic [15:0]        free_cnt;
  logic [ENTRY_W-1:0] res_value;
  logic [1:0]         res_status;

  logic        idx_in_table;
  logic [16:0] total_p2;
  logic [16:0] end_calc;
  logic        issue;
  logic        hit_zero;
  logic        scan_stop;
  logic        link_end;
  logic        link_out;

  // Decisions shared by the state and output logic.
  always_comb begin
    idx_in_table = {16'd0, idx} < TABLE_ENTRIES;
    total_p2     = {1'b0, total} + 17'd2;
    end_calc     = ({15'd0, total_p2} > TABLE_ENTRIES) ? 17'(TABLE_ENTRIES) : total_p2;
    issue        = scan_addr < scan_end;
    hit_zero     = pend && (mem_rd_data == '0);
    scan_stop    = ((op == OP_ALLOC) && hit_zero) || (!pend && !issue);
    link_end     = (link < 28'd2) || (link >= CHAIN_END_MIN);
    link_out     = {4'd0, link} >= TABLE_ENTRIES;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(TABLE_ENTRIES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (op)
          OP_READ:  state_next = idx_in_table ? S_RD_WAIT : S_DONE;
          OP_ALLOC: state_next = S_SCAN;
          OP_COUNT: state_next = S_SCAN;
          OP_FREE:  state_next = S_FREE_TEST;
          default:  state_next = S_DONE;
        endcase
      end
      S_RD_WAIT:   state_next = S_DONE;
      S_SCAN: begin
        if (scan_stop) state_next = S_DONE;
      end
      S_FREE_TEST: state_next = (link_end || link_out) ? S_DONE : S_FREE_WAIT;
      S_FREE_WAIT: state_next = S_FREE_TEST;
      S_DONE: begin
        if (res_take) state_next = S_IDLE;
      end
      default:     state_next = S_CLEAR;
    endcase
  end

  // Memory strobes and handshake outputs.
  always_comb begin
    mem_ctl     = '0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_addr = '0;
    busy        = (state != S_IDLE);
    res_valid   = (state == S_DONE);
    res.result_value = res_value;
    res.status       = res_status;
    unique case (state)
      S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        mem_wr_addr   = clr_addr;
        if (clr_addr == '0) begin
          mem_wr_data = MEDIA_MARK;
        end else if (clr_addr == AW'(1) || clr_addr == AW'(2)) begin
          mem_wr_data = END_OF_CHAIN;
        end
      end
      S_EXEC: begin
        mem_rd_addr = AW'(idx);
        mem_wr_addr = AW'(idx);
        mem_wr_data = val;
        mem_ctl.rd_en = (op == OP_READ) && idx_in_table;
        mem_ctl.wr_en = (op == OP_WRITE) && idx_in_table;
      end
      S_SCAN: begin
        mem_ctl.rd_en = issue;
        mem_rd_addr   = AW'(scan_addr);
        mem_ctl.wr_en = (op == OP_ALLOC) && hit_zero;
        mem_wr_addr   = AW'(pend_addr);
        mem_wr_data   = END_OF_CHAIN;
      end
      S_FREE_TEST: begin
        mem_ctl.rd_en = !(link_end || link_out);
        mem_rd_addr   = AW'(link);
      end
      S_FREE_WAIT: begin
        mem_ctl.wr_en = 1'b1;
        mem_wr_addr   = AW'(link);
      end
      default: begin
      end
    endcase
  end

  // State, work registers and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + AW'(1);
        S_IDLE: begin
          if (req_valid) begin
            op  <= req.opcode;
            idx <= req.entry_index;
            val <= req.entry_value;
          end
        end
        S_EXEC: begin
          res_value  <= '0;
          link       <= {12'd0, idx};
          scan_addr  <= 17'd2;
          scan_end   <= end_calc;
          pend       <= 1'b0;
          free_cnt   <= '0;
          if ((op == OP_READ || op == OP_WRITE) && !idx_in_table) begin
            res_status <= ST_RANGE;
          end else if (op == OP_ALLOC) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_OK;
          end
        end
        S_RD_WAIT: res_value <= mem_rd_data;
        S_SCAN: begin
          pend      <= issue;
          pend_addr <= scan_addr;
          if (issue) scan_addr <= scan_addr + 17'd1;
          if (hit_zero) begin
            free_cnt <= free_cnt + 16'd1;
            if (op == OP_ALLOC) begin
              res_value  <= {11'd0, pend_addr};
              res_status <= ST_OK;
            end
          end
          if (scan_stop && op == OP_COUNT) res_value <= {12'd0, free_cnt};
        end
        S_FREE_TEST: begin
          if (!link_end && link_out) res_status <= ST_RANGE;
        end
        S_FREE_WAIT: link <= mem_rd_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/fat_cluster_table_engine.sv =====
// Top level of the cluster table engine: register, output stage and checks.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | fct_req_t: opcode, entry_index, entry_value
//   rsp     | out       | rsp_valid/rsp_stall | fct_rsp_t: result_value, status
//   cfg     | in        | cfg_we              | cfg_wdata: cluster_total
//
// One request is worked at a time; every table access goes through one memory
// with a registered read port. Allocate scans the entries until it finds a free
// one, count scans the whole cluster range, and free walks the chain with one
// read and one clearing write per link. After reset a clearing pass writes the
// initial table to every entry; req_stall stays high meanwhile. A stalled result
// waits in the output register while the next request is accepted and worked.
`timescale 1ns / 1ps
module fat_cluster_table_engine
  import fct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = FCT_TABLE_ENTRIES,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  fct_req_t           req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output fct_rsp_t           rsp,
  input  logic               cfg_we,
  input  logic [TOTAL_W-1:0] cfg_wdata
);

  logic [TOTAL_W-1:0] total;
  logic               busy;
  logic               res_valid;
  logic               res_take;
  fct_rsp_t           res;
  fct_mem_ctl_t       mem_ctl;
  logic [AW-1:0]      mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;
  logic [AW-1:0]      mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;

  // Cluster total register.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= TOTAL_RESET;
    end else if (cfg_we) begin
      total <= cfg_wdata;
    end
  end

  assign req_stall = busy;

  // A finished word moves on once the output register is free or being emptied.
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (res_take) begin
      rsp <= res;
    end
  end

  fct_sequencer #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .busy        (busy),
    .total       (total),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_ctl     (mem_ctl),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  fct_table_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Reset always starts the clearing pass, so requests are held off.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request accepted straight after reset");

  // Only one request is worked at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request accepted while one is in work");

  // A finished word is held until the output register takes it.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("finished word lost before the output register took it");

  // Out of space always reports cluster zero.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> (rsp.result_value == '0))
    else $error("out-of-space word carries a cluster number");

endmodule
